### design/elevation_cut_rcs_binner_assert.svh
// assertion macros shared by the elevation cut binner modules
`ifndef ELEVATION_CUT_RCS_BINNER_ASSERT_SVH
`define ELEVATION_CUT_RCS_BINNER_ASSERT_SVH
`ifndef SYNTHESIS
`define ECRB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ECRB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ECRB_ASSERT(label, prop, msg)
`define ECRB_ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

### design/ecrb_pkg.sv
// shared types, constants and tables of the elevation cut binner
`timescale 1ns / 1ps
package ecrb_pkg;

  localparam int NUM_BINS     = 360;
  localparam int CORDIC_STEPS = 16;
  localparam int BIN_W        = $clog2(NUM_BINS);
  localparam int CNT_W        = (BIN_W > 6) ? BIN_W : 6;
  localparam int SUM_W        = 48;
  localparam int HITS_W       = 24;
  localparam int RAM_W        = SUM_W + HITS_W;
  localparam int CW           = 36;
  localparam int AW           = 27;
  localparam int DIV_STEPS    = SUM_W;
  localparam int SQ_STEPS     = 16;

  localparam logic [1:0] REG_AZ_OFF   = 2'd0;
  localparam logic [1:0] REG_HALF_W   = 2'd1;
  localparam logic [1:0] REG_DB_FLOOR = 2'd2;
  localparam logic [1:0] REG_MIN_INT  = 2'd3;

  typedef struct packed {
    logic signed [15:0] az_off;
    logic [14:0]        half_w;
    logic signed [15:0] db_floor;
    logic [31:0]        min_int;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic             az_start;
    logic             el_start;
    logic             cstep;
    logic             az_save;
    logic             el_save;
    logic             filt;
    logic             binq;
    logic             binc;
    logic             rd_bin;
    logic             rd_rb;
    logic             rcap;
    logic             div_step;
    logic             norm_start;
    logic             norm_step;
    logic             sq_init;
    logic             sq_step;
    logic             scale;
    logic             res_floor;
    logic             res_log;
    logic             clr_we;
    logic             upd_we;
    logic [CNT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic drop;
    logic rb_ok;
    logic keep;
    logic cnt_nz;
    logic mean_gt;
    logic t_top;
  } stat_t;

  // arctangent of 2^-i in 2^-16 degree units
  function automatic logic signed [AW-1:0] atan_q16(input logic [4:0] i);
    logic signed [AW-1:0] r;
    case (i)
      5'd0:  r = 27'sd2949120;
      5'd1:  r = 27'sd1740967;
      5'd2:  r = 27'sd919879;
      5'd3:  r = 27'sd466945;
      5'd4:  r = 27'sd234379;
      5'd5:  r = 27'sd117304;
      5'd6:  r = 27'sd58666;
      5'd7:  r = 27'sd29335;
      5'd8:  r = 27'sd14668;
      5'd9:  r = 27'sd7334;
      5'd10: r = 27'sd3667;
      5'd11: r = 27'sd1833;
      5'd12: r = 27'sd917;
      5'd13: r = 27'sd458;
      5'd14: r = 27'sd229;
      5'd15: r = 27'sd115;
      5'd16: r = 27'sd57;
      5'd17: r = 27'sd29;
      5'd18: r = 27'sd14;
      5'd19: r = 27'sd7;
      5'd20: r = 27'sd4;
      5'd21: r = 27'sd2;
      5'd22: r = 27'sd1;
      default: r = 27'sd0;
    endcase
    return r;
  endfunction

endpackage

### design/ecrb_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module ecrb_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### design/ecrb_ctrl.sv
// sequencing state machine of the elevation cut binner
`timescale 1ns / 1ps
module ecrb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  ecrb_pkg::stat_t st,
  output ecrb_pkg::cmd_t  cmd
);
  import ecrb_pkg::*;
  `include "elevation_cut_rcs_binner_assert.svh"

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DISP  = 5'd2;
  localparam logic [4:0] S_AZ    = 5'd3;
  localparam logic [4:0] S_AZEND = 5'd4;
  localparam logic [4:0] S_EL    = 5'd5;
  localparam logic [4:0] S_ELEND = 5'd6;
  localparam logic [4:0] S_FILT  = 5'd7;
  localparam logic [4:0] S_BINQ  = 5'd8;
  localparam logic [4:0] S_BINC  = 5'd9;
  localparam logic [4:0] S_RDA   = 5'd10;
  localparam logic [4:0] S_UPD   = 5'd11;
  localparam logic [4:0] S_RRD   = 5'd12;
  localparam logic [4:0] S_RCAP  = 5'd13;
  localparam logic [4:0] S_DIV   = 5'd14;
  localparam logic [4:0] S_MCMP  = 5'd15;
  localparam logic [4:0] S_NORM  = 5'd16;
  localparam logic [4:0] S_SQ    = 5'd17;
  localparam logic [4:0] S_SCALE = 5'd18;
  localparam logic [4:0] S_FIN   = 5'd19;
  localparam logic [4:0] S_RESF  = 5'd20;

  logic [4:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.idx    = cnt;
    case (state)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (cnt == CNT_W'(NUM_BINS - 1)) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        cnt_next = '0;
        if (st.is_read) begin
          state_next = st.rb_ok ? S_RRD : S_RESF;
        end else if (st.drop) begin
          state_next = S_IDLE;
        end else begin
          cmd.az_start = 1'b1;
          state_next   = S_AZ;
        end
      end
      S_AZ: begin
        cmd.cstep = 1'b1;
        if (cnt == CNT_W'(CORDIC_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = S_AZEND;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_AZEND: begin
        cmd.az_save  = 1'b1;
        cmd.el_start = 1'b1;
        state_next   = S_EL;
      end
      S_EL: begin
        cmd.cstep = 1'b1;
        if (cnt == CNT_W'(CORDIC_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = S_ELEND;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_ELEND: begin
        cmd.el_save = 1'b1;
        state_next  = S_FILT;
      end
      S_FILT: begin
        cmd.filt   = 1'b1;
        state_next = S_BINQ;
      end
      S_BINQ: begin
        if (st.keep) begin
          cmd.binq   = 1'b1;
          state_next = S_BINC;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_BINC: begin
        cmd.binc   = 1'b1;
        state_next = S_RDA;
      end
      S_RDA: begin
        cmd.rd_bin = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd_we = 1'b1;
        state_next = S_IDLE;
      end
      S_RRD: begin
        cmd.rd_rb  = 1'b1;
        state_next = S_RCAP;
      end
      S_RCAP: begin
        cmd.rcap   = 1'b1;
        cnt_next   = '0;
        state_next = st.cnt_nz ? S_DIV : S_RESF;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = S_MCMP;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_MCMP: begin
        if (st.mean_gt) begin
          cmd.norm_start = 1'b1;
          state_next     = S_NORM;
        end else begin
          state_next = S_RESF;
        end
      end
      S_NORM: begin
        if (st.t_top) begin
          cmd.sq_init = 1'b1;
          cnt_next    = '0;
          state_next  = S_SQ;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        if (cnt == CNT_W'(SQ_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = S_SCALE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.res_log = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_RESF: begin
        if (out_free) begin
          cmd.res_floor = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= (out_valid && out_stall) || cmd.res_log || cmd.res_floor;
    end
  end

  `ECRB_ASSERT_IMPL(a_res_slot_free, cmd.res_log || cmd.res_floor, out_free, "result overwrote a pending one")
  `ECRB_ASSERT_IMPL(a_clear_range, state == S_CLEAR, int'(cnt) < NUM_BINS, "clear address out of range")
endmodule

### design/ecrb_dp.sv
// datapath: cordic, slice filter, bin store, divider and log unit
`timescale 1ns / 1ps
module ecrb_dp (
  input  logic                clk,
  input  logic                rst,
  input  ecrb_pkg::cfg_t      cfg,
  input  ecrb_pkg::cmd_t      cmd,
  output ecrb_pkg::stat_t     st,
  input  logic                action,
  input  logic                missed,
  input  logic signed [15:0]  dir_x,
  input  logic signed [15:0]  dir_y,
  input  logic signed [15:0]  dir_z,
  input  logic signed [31:0]  intensity,
  input  logic [8:0]          read_bin,
  output logic [8:0]          bin_angle,
  output logic signed [15:0]  level_db,
  output logic                bin_valid
);
  import ecrb_pkg::*;
  `include "elevation_cut_rcs_binner_assert.svh"

  localparam logic signed [AW-1:0] DEG180 = 27'sd11796480;

  // captured request
  logic               act, miss;
  logic signed [15:0] xi, yi, zi;
  logic signed [31:0] inten;
  logic [8:0]         rb;

  // cordic
  logic signed [CW-1:0] cx, cy, sx, sy, xs, ys;
  logic signed [AW-1:0] ca;
  logic signed [33:0]   zk;
  logic                 xy_nz, any_nz;

  // filter and binning
  logic signed [19:0] az_h, el_h;
  logic signed [19:0] off0, off1, opp, d1, d2, dmin, w, vb;
  logic               keep_r, keep_c;
  logic [16:0]        vpos_r;
  logic [34:0]        bprod;
  logic [10:0]        bq;
  logic [BIN_W-1:0]   bin_addr, rb_addr;

  // store
  logic               ram_we, ram_re;
  logic [BIN_W-1:0]   ram_waddr, ram_raddr;
  logic [RAM_W-1:0]   ram_wdata, ram_rdata;
  logic [SUM_W-1:0]   rd_sum;
  logic [HITS_W-1:0]  rd_cnt;
  logic [SUM_W:0]     sum_add;

  // divider and log
  logic [SUM_W-1:0]   dq;
  logic [HITS_W-1:0]  rem, dsr;
  logic [HITS_W:0]    rem_sh;
  logic               cnt_nz_r;
  logic [SUM_W-1:0]   tn;
  logic [5:0]         nexp;
  logic [31:0]        nrm;
  logic [63:0]        sq;
  logic [15:0]        lfrac;
  logic signed [22:0] l2s;
  logic signed [47:0] prod_r, lsum;
  logic signed [15:0] lvl;

  function automatic logic signed [19:0] hund(input logic signed [AW-1:0] a);
    logic signed [AW+8:0] t;
    t = a * $signed(9'sd100);
    t = t + 32768;
    return 20'(t >>> 16);
  endfunction

  function automatic logic signed [19:0] ring(input logic signed [19:0] a,
                                              input logic signed [19:0] b);
    logic signed [19:0] d;
    d = a - b;
    if (d < 0) d = -d;
    if (d > 20'sd18000) d = 20'sd36000 - d;
    return d;
  endfunction

  assign xy_nz  = (xi != 0) || (yi != 0);
  assign any_nz = xy_nz || (zi != 0);
  assign zk     = zi * $signed(19'sd107922);
  assign rb_addr = BIN_W'(rb);
  assign {rd_sum, rd_cnt} = ram_rdata;

  // cordic source and step terms
  always_comb begin
    if (cmd.az_start) begin
      sx = CW'(xi) <<< 14;
      sy = CW'(yi) <<< 14;
    end else begin
      sx = xy_nz ? cx : '0;
      sy = CW'(zk >>> 2);
    end
    xs = cx >>> cmd.idx[4:0];
    ys = cy >>> cmd.idx[4:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act   <= action;
      miss  <= missed;
      xi    <= dir_x;
      yi    <= dir_y;
      zi    <= dir_z;
      inten <= intensity;
      rb    <= read_bin;
    end
    if (cmd.az_start || cmd.el_start) begin
      // fold the left half plane over with a start angle of +-180
      if (sx < 0) begin
        ca <= (sy >= 0) ? DEG180 : -DEG180;
        cx <= -sx;
        cy <= -sy;
      end else begin
        ca <= '0;
        cx <= sx;
        cy <= sy;
      end
    end else if (cmd.cstep) begin
      if (cy >= 0) begin
        cx <= cx + ys;
        cy <= cy - xs;
        ca <= ca + atan_q16(cmd.idx[4:0]);
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        ca <= ca - atan_q16(cmd.idx[4:0]);
      end
    end
    if (cmd.az_save) az_h <= xy_nz ? hund(ca) : '0;
    if (cmd.el_save) el_h <= any_nz ? hund(ca) : '0;
  end

  // slice test and bin position
  always_comb begin
    off0 = 20'(cfg.az_off);
    if (off0 >= 20'sd18000) off1 = off0 - 20'sd36000;
    else if (off0 < -20'sd18000) off1 = off0 + 20'sd36000;
    else off1 = off0;
    opp = off1 + 20'sd18000;
    if (opp >= 20'sd18000) opp = opp - 20'sd36000;
    d1 = ring(az_h, off1);
    d2 = ring(az_h, opp);
    dmin = (d2 < d1) ? d2 : d1;
    keep_c = (dmin <= $signed({5'd0, cfg.half_w}));
    w = az_h - off1;
    if (w > 20'sd18000) w = w - 20'sd36000;
    if (w < -20'sd18000) w = w + 20'sd36000;
    if ((w <= 20'sd9000) && (w >= -20'sd9000)) vb = el_h + 20'sd9050;
    else vb = 20'sd27050 - el_h;
  end

  assign bq = bprod[34:24];

  always_ff @(posedge clk) begin
    if (cmd.filt) begin
      keep_r <= keep_c;
      vpos_r <= (vb < 0) ? '0 : 17'(vb);
    end
    // floor(v / 100) by reciprocal, exact over the v range
    if (cmd.binq) bprod <= {18'd0, vpos_r} * 35'd167773;
    if (cmd.binc) begin
      if (32'(bq) > NUM_BINS - 1) bin_addr <= BIN_W'(NUM_BINS - 1);
      else bin_addr <= BIN_W'(bq);
    end
  end

  // bin store port control
  assign sum_add = {1'b0, rd_sum} + {{(SUM_W - 31){1'b0}}, inten[30:0]};

  always_comb begin
    ram_re    = cmd.rd_bin || cmd.rd_rb;
    ram_raddr = cmd.rd_bin ? bin_addr : rb_addr;
    ram_we    = 1'b0;
    ram_waddr = rb_addr;
    ram_wdata = '0;
    if (cmd.clr_we) begin
      ram_we    = 1'b1;
      ram_waddr = cmd.idx[BIN_W-1:0];
    end else if (cmd.upd_we) begin
      ram_we    = (rd_cnt != '1);
      ram_waddr = bin_addr;
      ram_wdata = {sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0], rd_cnt + 1'b1};
    end else if (cmd.rcap) begin
      ram_we = 1'b1;
    end
  end

  ecrb_ram #(.W(RAM_W), .D(NUM_BINS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // restoring divider, squaring log2, scale to hundredths of dB
  assign rem_sh = {rem, dq[SUM_W-1]};
  assign sq     = nrm * nrm;
  assign l2s    = $signed({1'b0, nexp, lfrac}) - 23'sd1048576;
  assign lsum   = prod_r + 48'sd2147483648;
  assign lvl    = lsum[47:32];

  always_ff @(posedge clk) begin
    if (cmd.rcap) begin
      dq       <= rd_sum;
      dsr      <= rd_cnt;
      rem      <= '0;
      cnt_nz_r <= (rd_cnt != '0);
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, dsr}) begin
        rem <= HITS_W'(rem_sh - {1'b0, dsr});
        dq  <= {dq[SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[HITS_W-1:0];
        dq  <= {dq[SUM_W-2:0], 1'b0};
      end
    end
    if (cmd.norm_start) begin
      tn   <= dq;
      nexp <= 6'(SUM_W - 1);
    end else if (cmd.norm_step) begin
      tn   <= {tn[SUM_W-2:0], 1'b0};
      nexp <= nexp - 1'b1;
    end
    if (cmd.sq_init) begin
      nrm   <= tn[SUM_W-1:SUM_W-32];
      lfrac <= '0;
    end else if (cmd.sq_step) begin
      if (sq[63]) begin
        nrm   <= sq[63:32];
        lfrac <= lfrac | (16'h8000 >> cmd.idx[3:0]);
      end else begin
        nrm <= sq[62:31];
      end
    end
    if (cmd.scale) prod_r <= 48'(l2s) * 48'sd19728302;
    if (cmd.res_floor) begin
      bin_angle <= rb;
      level_db  <= cfg.db_floor;
      bin_valid <= st.rb_ok && cnt_nz_r;
    end else if (cmd.res_log) begin
      bin_angle <= rb;
      level_db  <= (lvl > cfg.db_floor) ? lvl : cfg.db_floor;
      bin_valid <= 1'b1;
    end
  end

  always_comb begin
    st.is_read = act;
    st.drop    = miss || inten[31];
    st.rb_ok   = (32'(rb) < NUM_BINS);
    st.keep    = keep_r;
    st.cnt_nz  = (rd_cnt != '0);
    st.mean_gt = (dq > {{(SUM_W - 32){1'b0}}, cfg.min_int});
    st.t_top   = tn[SUM_W-1];
  end

  `ECRB_ASSERT_IMPL(a_sq_normalized, cmd.sq_step, nrm[31], "log mantissa lost normalization")
  `ECRB_ASSERT_IMPL(a_div_rem, cmd.div_step, rem < dsr, "divider remainder not below divisor")
endmodule

### design/elevation_cut_rcs_binner.sv
// Top level of the elevation cut binner: configuration registers and unit wiring.
// Add request: two 16-step CORDIC runs on one unit; in_stall holds off the next request until it is done.
// Read request: a level takes a 48-step divider, a normalize search and 16 squarings, while floor
// results skip the later steps; the last step waits while an earlier result is still stalled.
// Reset (synchronous) clears the bin store in one pass over all NUM_BINS bins, one bin per cycle,
// with in_stall high; registers return to offset 0, half width 100, floor -10000, minimum 0.
`timescale 1ns / 1ps
module elevation_cut_rcs_binner (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic               missed,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic signed [31:0] intensity,
  input  logic [8:0]         read_bin,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [8:0]         bin_angle,
  output logic signed [15:0] level_db,
  output logic               bin_valid
);
  import ecrb_pkg::*;

  cfg_t       cfg;
  cmd_t       cmd;
  stat_t      st;
  logic       wr_en;
  logic [1:0] reg_idx;

  // register index from the word address; writes land on the access phase
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.az_off   <= 16'sd0;
      cfg.half_w   <= 15'd100;
      cfg.db_floor <= -16'sd10000;
      cfg.min_int  <= 32'd0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_AZ_OFF:   cfg.az_off   <= pwdata[15:0];
        REG_HALF_W:   cfg.half_w   <= pwdata[14:0];
        REG_DB_FLOOR: cfg.db_floor <= pwdata[15:0];
        REG_MIN_INT:  cfg.min_int  <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // read back the raw register bits
  always_comb begin
    case (reg_idx)
      REG_AZ_OFF:   prdata = {16'd0, cfg.az_off};
      REG_HALF_W:   prdata = {17'd0, cfg.half_w};
      REG_DB_FLOOR: prdata = {16'd0, cfg.db_floor};
      REG_MIN_INT:  prdata = cfg.min_int;
      default:      prdata = '0;
    endcase
  end

  // sequencer: clear pass, cordic runs, store update, divide and log
  ecrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // arithmetic, bin store and result register
  ecrb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .st        (st),
    .action    (action),
    .missed    (missed),
    .dir_x     (dir_x),
    .dir_y     (dir_y),
    .dir_z     (dir_z),
    .intensity (intensity),
    .read_bin  (read_bin),
    .bin_angle (bin_angle),
    .level_db  (level_db),
    .bin_valid (bin_valid)
  );
endmodule
